>>> rtl/float_unsigned_int_converter_defines.svh
// Assertion macros for the float/unsigned-integer converter.
// Used by the checker module only; no other dependencies.
`ifndef FLOAT_UNSIGNED_INT_CONVERTER_DEFINES_SVH
`define FLOAT_UNSIGNED_INT_CONVERTER_DEFINES_SVH

// Implication checked every clock, off during reset.
`define FUIC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define FUIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fuic_pkg.sv
// Package for the float/unsigned-integer converter: opcodes, trap codes, payload types.
// No dependencies.
package fuic_pkg;

  typedef enum logic [2:0] {
    OP_F32_U32 = 3'd0, OP_F64_U32 = 3'd1, OP_F32_U64 = 3'd2, OP_F64_U64 = 3'd3,
    OP_U32_F32 = 3'd4, OP_U64_F32 = 3'd5, OP_U32_F64 = 3'd6, OP_U64_F64 = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    TRAP_NONE = 2'd0, TRAP_INVALID = 2'd1, TRAP_OVERFLOW = 2'd2
  } trap_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] operand_bits;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic [1:0]  trap_code;
  } out_item_t;

endpackage

>>> rtl/fuic_if.sv
// Valid/ready channel interfaces for the converter.
// Depends on fuic_pkg.
interface fuic_in_if (input logic clk);
  logic                 valid;
  logic                 ready;
  fuic_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fuic_out_if (input logic clk);
  logic                 valid;
  logic                 ready;
  fuic_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/float_unsigned_int_converter.sv
// Top level of the float/unsigned-integer converter.
// Depends on fuic_pkg, fuic_if and fuic_core.
// One transaction in, one out, every cycle while out_ready is high: input register, one
// combinational pass through fuic_core, result register. The result is shown from the
// result register once the core output has been captured there; a stalled output
// holds the result register and the stage behind it still fills, so throughput is one
// item per cycle while out_ready is high.
module float_unsigned_int_converter (
  input  logic       clk,
  input  logic       rst_n,
  fuic_in_if.sink    in_ch,
  fuic_out_if.source out_ch
);
  import fuic_pkg::*;

  logic      s1_valid_r, s2_valid_r;
  in_item_t  s1_data_r;
  out_item_t s2_data_r, core_res;
  logic      s2_take, s1_take;

  assign s2_take = !s2_valid_r || out_ch.ready;
  assign s1_take = !s1_valid_r || s2_take;
  assign in_ch.ready = s1_take;

  fuic_core u_core (.item(s1_data_r), .res(core_res));

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (s1_take) s1_valid_r <= in_ch.valid;
    if (s1_take && in_ch.valid) s1_data_r <= in_ch.data;
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else if (s2_take) s2_valid_r <= s1_valid_r;
    if (s2_take && s1_valid_r) s2_data_r <= core_res;
  end

  assign out_ch.valid = s2_valid_r;
  assign out_ch.data  = s2_data_r;
endmodule

>>> rtl/fuic_core.sv
// Combinational conversion datapath: float truncation and integer-to-float rounding.
// Depends on fuic_pkg.
module fuic_core (
  input  fuic_pkg::in_item_t  item,
  output fuic_pkg::out_item_t res
);
  import fuic_pkg::*;

  // Float fields, unified to f64 layout
  logic        is_d, tgt64, neg, is_nan, is_inf;
  logic [10:0] expf;
  logic [52:0] sig;
  logic [11:0] e_unb;   // unbiased exponent when positive
  logic        below_one;
  logic [6:0]  limit;
  logic [115:0] shifted;
  logic [63:0] trunc_val;
  logic [1:0]  trap;

  always_comb begin
    is_d  = item.opcode[0];
    tgt64 = item.opcode[1];
    if (is_d) begin
      neg    = item.operand_bits[63];
      expf   = item.operand_bits[62:52];
      sig    = {1'b1, item.operand_bits[51:0]};
      is_nan = (expf == 11'h7ff) && (item.operand_bits[51:0] != '0);
      is_inf = (expf == 11'h7ff);
      below_one = (expf < 11'd1023);
      e_unb  = {1'b0, expf} - 12'd1023;
    end else begin
      neg    = item.operand_bits[31];
      expf   = {3'b0, item.operand_bits[30:23]};
      sig    = {1'b1, item.operand_bits[22:0], 29'b0};
      is_nan = (expf == 11'hff) && (item.operand_bits[22:0] != '0);
      is_inf = (expf == 11'hff);
      below_one = (expf < 11'd127);
      e_unb  = {1'b0, expf} - 12'd127;
    end
    limit = tgt64 ? 7'd64 : 7'd32;
    // value = sig * 2^(e-52); place bit 52 at position 52+e, integer part above bit 51
    shifted = {63'b0, sig} << e_unb[5:0];
    trunc_val = shifted[115:52];
    if (is_nan)                    trap = TRAP_INVALID;
    else if (is_inf)               trap = TRAP_OVERFLOW;
    else if (below_one)            trap = TRAP_NONE;
    else if (neg || e_unb >= {5'b0, limit}) trap = TRAP_OVERFLOW;
    else                           trap = TRAP_NONE;
  end

  // Integer to float
  logic [63:0] v, norm;
  logic [5:0]  p;
  logic        found, dbl, up;
  logic [53:0] keep;   // mantissa with hidden bit and carry room
  logic        g, st;
  logic [10:0] expo;
  logic [63:0] fres;

  always_comb begin
    dbl = item.opcode[1];
    v   = item.opcode[0] ? item.operand_bits : {32'b0, item.operand_bits[31:0]};
    p = '0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        p = 6'(i);
        found = 1'b1;
      end
    end
    norm = v << (6'd63 - p);   // leading one at bit 63
    if (dbl) begin
      keep = {1'b0, norm[63:11]};
      g    = norm[10];
      st   = norm[9:0] != '0;
    end else begin
      keep = {30'b0, norm[63:40]};
      g    = norm[39];
      st   = norm[38:0] != '0;
    end
    up   = g && (st || keep[0]);
    keep = keep + {53'b0, up};
    expo = {5'b0, p} + (dbl ? 11'd1023 : 11'd127);
    if (dbl) begin
      if (keep[53]) expo = expo + 11'd1;
      fres = {1'b0, expo, keep[51:0]};
    end else begin
      if (keep[24]) expo = expo + 11'd1;
      fres = {33'b0, expo[7:0], keep[22:0]};
    end
    if (!found) fres = '0;
  end

  always_comb begin
    if (item.opcode[2]) begin
      res.result_bits = fres;
      res.trap_code   = TRAP_NONE;
    end else begin
      res.result_bits = (trap == TRAP_NONE && !below_one) ? trunc_val : '0;
      res.trap_code   = trap;
    end
  end
endmodule

>>> rtl/fuic_checker.sv
// Port-level checker for the converter, bound to the top level.
// Depends on fuic_pkg and float_unsigned_int_converter_defines.svh.
`include "float_unsigned_int_converter_defines.svh"
module fuic_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fuic_pkg::out_item_t out_data
);
  import fuic_pkg::*;

  // Stalled result holds
  `FUIC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  // Trapping results carry zero bits
  `FUIC_ASSERT(a_zero, out_valid && out_data.trap_code != TRAP_NONE, out_data.result_bits == '0, "trap with data")
  // Trap code is a defined one
  `FUIC_ASSERT(a_code, out_valid, out_data.trap_code != 2'd3, "bad trap code")
  // Input never blocked while output drains
  `FUIC_ASSERT(a_ready, out_ready, in_ready, "input stalled with free output")
endmodule

bind float_unsigned_int_converter fuic_checker u_fuic_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

>>> tb/fuic_conv_scoreboard.sv
// Conversion scoreboard for the float/unsigned-integer converter testbench.
// Depends on fuic_pkg; holds the bit-exact predictor and the queue of pending results.
class fuic_conv_scoreboard;
  fuic_pkg::out_item_t pending_results[$];
  int unsigned mismatch_count;

  function new();
    mismatch_count = 0;
  endfunction

  // Truncate a float toward zero into an unsigned integer of out_w bits
  static function fuic_pkg::out_item_t trunc_to_uint(logic [63:0] bits, int ebits,
                                                     int mbits, int out_w);
    fuic_pkg::out_item_t r;
    logic [63:0] mant, expf, exp_max, sig;
    logic neg;
    int e;
    exp_max = (64'd1 << ebits) - 1;
    mant = bits & ((64'd1 << mbits) - 1);
    expf = (bits >> mbits) & exp_max;
    neg = bits[mbits + ebits];
    r.result_bits = '0;
    r.trap_code = fuic_pkg::TRAP_NONE;
    e = int'(expf) - int'(exp_max >> 1);
    if (expf == exp_max) begin
      r.trap_code = (mant != 0) ? fuic_pkg::TRAP_INVALID : fuic_pkg::TRAP_OVERFLOW;
    end else if (expf == 0 || e < 0) begin
      // magnitude below one
    end else if (neg || e >= out_w) begin
      r.trap_code = fuic_pkg::TRAP_OVERFLOW;
    end else begin
      sig = mant | (64'd1 << mbits);
      r.result_bits = (e >= mbits) ? sig << (e - mbits) : sig >> (mbits - e);
    end
    return r;
  endfunction

  // Unsigned integer to float, round to nearest even
  static function logic [63:0] uint_to_fp(logic [63:0] v, int mbits, int bias);
    int p, sh;
    logic [63:0] expo, keep, rem, half;
    if (v == 0) return '0;
    p = 63;
    while (!v[p]) p--;
    expo = p + bias;
    if (p <= mbits) begin
      keep = v << (mbits - p);
    end else begin
      sh = p - mbits;
      rem = v & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      keep = v >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
      if ((keep >> (mbits + 1)) != 0) begin
        keep >>= 1;
        expo++;
      end
    end
    return (expo << mbits) | (keep & ((64'd1 << mbits) - 1));
  endfunction

  static function fuic_pkg::out_item_t convert(fuic_pkg::in_item_t it);
    fuic_pkg::out_item_t r;
    logic [63:0] x, lo;
    x = it.operand_bits;
    lo = {32'd0, x[31:0]};
    r.trap_code = fuic_pkg::TRAP_NONE;
    case (fuic_pkg::opcode_t'(it.opcode))
      fuic_pkg::OP_F32_U32: r = trunc_to_uint(lo, 8, 23, 32);
      fuic_pkg::OP_F64_U32: r = trunc_to_uint(x, 11, 52, 32);
      fuic_pkg::OP_F32_U64: r = trunc_to_uint(lo, 8, 23, 64);
      fuic_pkg::OP_F64_U64: r = trunc_to_uint(x, 11, 52, 64);
      fuic_pkg::OP_U32_F32: r.result_bits = uint_to_fp(lo, 23, 127);
      fuic_pkg::OP_U64_F32: r.result_bits = uint_to_fp(x, 23, 127);
      fuic_pkg::OP_U32_F64: r.result_bits = uint_to_fp(lo, 52, 1023);
      default:              r.result_bits = uint_to_fp(x, 52, 1023);
    endcase
    return r;
  endfunction

  function void note_operation(fuic_pkg::in_item_t it);
    pending_results.push_back(convert(it));
  endfunction

  function void check_result(fuic_pkg::out_item_t got);
    fuic_pkg::out_item_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result bits=%h trap=%0d", $time, got.result_bits,
               got.trap_code);
      mismatch_count++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.result_bits !== exp.result_bits) begin
      $display("%0t: result_bits expected %h actual %h", $time, exp.result_bits,
               got.result_bits);
      mismatch_count++;
    end
    if (got.trap_code !== exp.trap_code) begin
      $display("%0t: trap_code expected %0d actual %0d", $time, exp.trap_code,
               got.trap_code);
      mismatch_count++;
    end
  endfunction
endclass

>>> tb/testbench.sv
// Top-level testbench for float_unsigned_int_converter: directed and random conversions
// with random idling and back-pressure. Depends on fuic_pkg, fuic_if, the scoreboard class.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fuic_pkg::*;

  logic clk;
  logic rst_n;
  fuic_in_if  in_ch (clk);
  fuic_out_if out_ch (clk);

  float_unsigned_int_converter dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  fuic_conv_scoreboard conv_sb = new();
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_cycles;
  longint unsigned cycle_count;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls plus long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) conv_sb.check_result(out_ch.data);
  end

  // Offer one operation, idling first at random; returns after acceptance with valid
  // still high, the next call replaces it or idles, or wait_drained drops it
  task automatic send_op(opcode_t op, logic [63:0] operand);
    in_item_t it;
    it.opcode = op;
    it.operand_bits = operand;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    conv_sb.note_operation(it);
  endtask

  // Random operand shaped toward interesting ranges for the opcode
  function automatic logic [63:0] pick_operand(opcode_t op);
    logic [63:0] v;
    int sel;
    v = {$urandom, $urandom};
    sel = $urandom_range(9);
    if (op <= OP_F64_U64) begin
      if (op == OP_F32_U32 || op == OP_F32_U64) begin
        // exponent near the interesting band for binary32
        if (sel < 7) v[30:23] = 8'(120 + $urandom_range(75));
        else if (sel == 7) v[30:23] = 8'hff;
        else if (sel == 8) v[30:23] = 8'h00;
      end else begin
        if (sel < 7) v[62:52] = 11'(1016 + $urandom_range(75));
        else if (sel == 7) v[62:52] = 11'h7ff;
        else if (sel == 8) v[62:52] = 11'h000;
      end
      if (sel < 7 && $urandom_range(3) != 0) v[63] = 1'b0;
      if (sel < 7 && $urandom_range(3) != 0) v[31] = 1'b0;
    end else begin
      if (sel < 5) v = v >> $urandom_range(63);
    end
    return v;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (conv_sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    opcode_t op;
    repeat (n) begin
      op = opcode_t'($urandom_range(7));
      send_op(op, pick_operand(op));
    end
  endtask

  initial begin
    in_item_t blank;
    blank = '0;
    cycle_count = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = blank;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: NaN, infinities, below one, at or below -1, limits, rounding ties
    send_op(OP_F32_U32, 64'hFFFF_FFFF_7FC0_0001);
    send_op(OP_F64_U64, 64'hFFF8_0000_0000_0000);
    send_op(OP_F32_U64, 64'h0000_0000_FF80_0000);
    send_op(OP_F64_U32, 64'h7FF0_0000_0000_0000);
    send_op(OP_F32_U32, 64'h0000_0000_8000_0000);
    send_op(OP_F32_U32, 64'h0000_0000_BF7F_FFFF);
    send_op(OP_F64_U64, 64'h0000_0000_0000_0001);
    send_op(OP_F32_U32, 64'h0000_0000_BF80_0000);
    send_op(OP_F64_U32, 64'h41EF_FFFF_FFF0_0000);
    send_op(OP_F64_U32, 64'h41F0_0000_0000_0000);
    send_op(OP_F32_U32, 64'h0000_0000_4F7F_FFFF);
    send_op(OP_F32_U32, 64'h0000_0000_4F80_0000);
    send_op(OP_F64_U64, 64'h43EF_FFFF_FFFF_FFFF);
    send_op(OP_F64_U64, 64'h43F0_0000_0000_0000);
    send_op(OP_F32_U64, 64'h0000_0000_5F7F_FFFF);
    send_op(OP_U32_F32, 64'hFFFF_FFFF_0000_0000);
    send_op(OP_U32_F32, 64'h0000_0000_FFFF_FFFF);
    send_op(OP_U64_F32, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_U32_F64, 64'hABCD_0000_FFFF_FFFF);
    send_op(OP_U64_F64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_U32_F32, 64'h0000_0000_0100_0001);
    send_op(OP_U32_F32, 64'h0000_0000_0100_0003);
    send_op(OP_U64_F64, 64'h0020_0000_0000_0001);
    send_op(OP_U64_F64, 64'h0000_0000_0000_0000);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    hold_cycles = 40;
    random_phase(30);
    // Sender pause until every result is back
    wait_drained();

    send_idle_pct = 7;
    recv_idle_pct = 52;
    random_phase(370);
    send_idle_pct = 52;
    recv_idle_pct = 7;
    random_phase(370);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(360);

    wait_drained();
    repeat (10) @(posedge clk);
    if (conv_sb.mismatch_count == 0 && conv_sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/fuic_pkg.sv
rtl/fuic_if.sv
rtl/fuic_core.sv
rtl/float_unsigned_int_converter.sv
rtl/fuic_checker.sv
tb/fuic_conv_scoreboard.sv
tb/testbench.sv
